[src/fdsa_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// fdsa_pkg: shared types and codes for the Forth data stack ALU
// Opcodes, result kinds, error codes and the beat structs of both channels.
// ============================================================================
package fdsa_pkg;

    localparam int WORD_W            = 32;
    localparam int STACK_ENTRIES_DEF = 32;

    // opcodes
    localparam logic [3:0] MODE_PUSH  = 4'd0;
    localparam logic [3:0] MODE_ADD   = 4'd1;
    localparam logic [3:0] MODE_SUB   = 4'd2;
    localparam logic [3:0] MODE_MUL   = 4'd3;
    localparam logic [3:0] MODE_DIV   = 4'd4;
    localparam logic [3:0] MODE_DUP   = 4'd5;
    localparam logic [3:0] MODE_DROP  = 4'd6;
    localparam logic [3:0] MODE_SWAP  = 4'd7;
    localparam logic [3:0] MODE_OVER  = 4'd8;
    localparam logic [3:0] MODE_PRINT = 4'd9;
    localparam logic [3:0] MODE_EMIT  = 4'd10;
    localparam logic [3:0] MODE_SHOW  = 4'd11;

    // result kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_NUMBER = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_DEPTH  = 3'd3;
    localparam logic [2:0] KIND_ENTRY  = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
    localparam logic [1:0] ERR_DIV_ZERO  = 2'd3;

    typedef struct packed {
        logic [3:0]               mode;
        logic signed [WORD_W-1:0] literal;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [WORD_W-1:0] value;
        logic [1:0]               error;
        logic                     last;
    } rsp_beat_t;

endpackage

[src/forth_data_stack_alu.sv]
`timescale 1ns / 1ps
// ============================================================================
// forth_data_stack_alu: Forth data stack with a 32-bit ALU
// Bounded data stack in RAM, worked by a small sequencer around one shared
// adder (add, subtract, divide steps, sign fix) plus a 32x32 multiplier.
// ============================================================================
// Usage:
//   cmd channel: one beat per Forth word (mode, literal). The block takes a
//   beat only when idle; cmd_stall is high while an item is in progress.
//   rsp channel: one or more beats per item (kind, value, error, last); last
//   marks the final beat of an item. Only show gives more than one beat.
// Sequence per item: push, drop, unused modes and underflow answer straight
//   from idle; dup, print, emit and a zero divisor read the top entry;
//   swap and over also read the second entry, swap then writing both back;
//   add, sub and mul then execute; div runs 32 divide steps and a sign fix;
//   show loads the depth beat, then one beat per entry from the top down.
// Throughput: one item at a time; the next beat is taken in the cycle after
// the final beat is loaded. The divide loop, one quotient bit per cycle
// through the shared adder, and the stack walk of show, one RAM read per
// entry, set the worst case.
// Reset clears the depth (empty stack), the sequencer and the rsp valid. The
// RAM is not cleared: only entries below the depth are ever read.
// A stalled rsp beat holds; the sequencer waits until the output register
// frees before loading the next beat.
// ============================================================================
module forth_data_stack_alu #(
    parameter int STACK_ENTRIES = fdsa_pkg::STACK_ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  fdsa_pkg::cmd_beat_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output fdsa_pkg::rsp_beat_t rsp
);

    localparam int AW = $clog2(STACK_ENTRIES);
    localparam int DW = $clog2(STACK_ENTRIES + 1);
    localparam int W  = fdsa_pkg::WORD_W;
    localparam int CW = $clog2(W);

    typedef enum logic [9:0] {
        ST_IDLE       = 10'b00_0000_0001,
        ST_RD_B       = 10'b00_0000_0010,
        ST_RD_A       = 10'b00_0000_0100,
        ST_EXEC       = 10'b00_0000_1000,
        ST_DIV        = 10'b00_0001_0000,
        ST_DIV_FIN    = 10'b00_0010_0000,
        ST_SWAP2      = 10'b00_0100_0000,
        ST_RESP       = 10'b00_1000_0000,
        ST_SHOW_DEPTH = 10'b01_0000_0000,
        ST_SHOW_ENT   = 10'b10_0000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [3:0]          mode_reg, mode_next;
    logic [DW-1:0]       depth_reg, depth_next;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [W-1:0]        quo_reg, quo_next;
    logic [W-1:0]        dvs_reg, dvs_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [2:0]          kind_reg, kind_next;
    logic [W-1:0]        val_reg, val_next;
    logic [1:0]          err_reg, err_next;
    logic                rsp_valid_reg, rsp_valid_next;
    fdsa_pkg::rsp_beat_t rsp_reg, rsp_next;

    // stack RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [W-1:0]  ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [W-1:0]  ram_rdata;

    // shared adder
    logic [W-1:0]  alu_x, alu_y;
    logic          alu_cin;
    logic [W:0]    alu_sum;
    logic [W-1:0]  div_shift;
    logic [W-1:0]  mul_lo;

    logic          cmd_take;
    logic          rsp_free;
    logic          rsp_load;
    logic          stack_full;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] second_addr;
    logic [AW-1:0] push_addr;

    assign cmd_take    = cmd_valid && !cmd_stall;
    assign cmd_stall   = (state_reg != ST_IDLE);
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;
    assign stack_full  = (depth_reg == DW'(STACK_ENTRIES));
    assign top_addr    = AW'(depth_reg - DW'(1));
    assign second_addr = AW'(depth_reg - DW'(2));
    assign push_addr   = AW'(depth_reg);

    // remainder shifted left by one with the next dividend bit brought in
    assign div_shift = {rem_reg[W-2:0], quo_reg[W-1]};
    assign mul_lo    = W'(a_reg * b_reg);

    always_comb
    begin
        alu_x   = a_reg;
        alu_y   = b_reg;
        alu_cin = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (mode_reg == fdsa_pkg::MODE_SUB)
                begin
                    alu_y   = ~b_reg;
                    alu_cin = 1'b1;
                end
            end
            ST_DIV:
            begin
                alu_x   = div_shift;
                alu_y   = ~dvs_reg;
                alu_cin = 1'b1;
            end
            ST_DIV_FIN:
            begin
                alu_x   = neg_reg ? ~quo_reg : quo_reg;
                alu_y   = '0;
                alu_cin = neg_reg;
            end
            default:
            begin
            end
        endcase
    end

    // carry out of a subtract is set when the minuend is not below
    assign alu_sum = {1'b0, alu_x} + {1'b0, alu_y} + (W+1)'(alu_cin);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        depth_next     = depth_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        err_next       = err_reg;
        rsp_load       = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = push_addr;
        ram_wdata      = b_reg;
        ram_re         = 1'b0;
        ram_raddr      = top_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    mode_next  = cmd.mode;
                    kind_next  = fdsa_pkg::KIND_STATUS;
                    val_next   = '0;
                    err_next   = fdsa_pkg::ERR_NONE;
                    state_next = ST_RESP;
                    unique case (cmd.mode) inside
                        fdsa_pkg::MODE_PUSH:
                        begin
                            if (stack_full)
                            begin
                                err_next = fdsa_pkg::ERR_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = push_addr;
                                ram_wdata  = cmd.literal;
                                depth_next = depth_reg + DW'(1);
                            end
                        end
                        fdsa_pkg::MODE_ADD, fdsa_pkg::MODE_SUB, fdsa_pkg::MODE_MUL,
                        fdsa_pkg::MODE_DIV, fdsa_pkg::MODE_SWAP, fdsa_pkg::MODE_OVER:
                        begin
                            if (depth_reg < DW'(2))
                            begin
                                err_next = fdsa_pkg::ERR_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = top_addr;
                                state_next = ST_RD_B;
                            end
                        end
                        fdsa_pkg::MODE_DUP, fdsa_pkg::MODE_PRINT, fdsa_pkg::MODE_EMIT:
                        begin
                            if (depth_reg == '0)
                            begin
                                err_next = fdsa_pkg::ERR_UNDERFLOW;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = top_addr;
                                state_next = ST_RD_B;
                            end
                        end
                        fdsa_pkg::MODE_DROP:
                        begin
                            if (depth_reg == '0)
                            begin
                                err_next = fdsa_pkg::ERR_UNDERFLOW;
                            end
                            else
                            begin
                                depth_next = depth_reg - DW'(1);
                            end
                        end
                        fdsa_pkg::MODE_SHOW:
                        begin
                            state_next = ST_SHOW_DEPTH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RD_B:
            begin
                b_next     = ram_rdata;
                state_next = ST_RESP;
                unique case (mode_reg) inside
                    fdsa_pkg::MODE_DUP:
                    begin
                        if (stack_full)
                        begin
                            err_next = fdsa_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = push_addr;
                            ram_wdata  = ram_rdata;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    fdsa_pkg::MODE_PRINT:
                    begin
                        kind_next  = fdsa_pkg::KIND_NUMBER;
                        val_next   = ram_rdata;
                        depth_next = depth_reg - DW'(1);
                    end
                    fdsa_pkg::MODE_EMIT:
                    begin
                        kind_next  = fdsa_pkg::KIND_CHAR;
                        val_next   = {{(W-8){1'b0}}, ram_rdata[7:0]};
                        depth_next = depth_reg - DW'(1);
                    end
                    default:
                    begin
                        if (mode_reg == fdsa_pkg::MODE_DIV && ram_rdata == '0)
                        begin
                            // drop the zero divisor, keep the dividend
                            err_next   = fdsa_pkg::ERR_DIV_ZERO;
                            depth_next = depth_reg - DW'(1);
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = second_addr;
                            state_next = ST_RD_A;
                        end
                    end
                endcase
            end

            ST_RD_A:
            begin
                a_next     = ram_rdata;
                state_next = ST_RESP;
                unique case (mode_reg) inside
                    fdsa_pkg::MODE_SWAP:
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = top_addr;
                        ram_wdata  = ram_rdata;
                        state_next = ST_SWAP2;
                    end
                    fdsa_pkg::MODE_OVER:
                    begin
                        if (stack_full)
                        begin
                            err_next = fdsa_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = push_addr;
                            ram_wdata  = ram_rdata;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    default:
                    begin
                        state_next = ST_EXEC;
                    end
                endcase
            end

            ST_SWAP2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = second_addr;
                ram_wdata  = b_reg;
                state_next = ST_RESP;
            end

            ST_EXEC:
            begin
                if (mode_reg == fdsa_pkg::MODE_DIV)
                begin
                    // divide magnitudes, fix the sign at the end
                    quo_next   = a_reg[W-1] ? (~a_reg + W'(1)) : a_reg;
                    dvs_next   = b_reg[W-1] ? (~b_reg + W'(1)) : b_reg;
                    neg_next   = a_reg[W-1] ^ b_reg[W-1];
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = second_addr;
                    ram_wdata  = (mode_reg == fdsa_pkg::MODE_MUL) ? mul_lo : alu_sum[W-1:0];
                    depth_next = depth_reg - DW'(1);
                    state_next = ST_RESP;
                end
            end

            ST_DIV:
            begin
                rem_next = alu_sum[W] ? alu_sum[W-1:0] : div_shift;
                quo_next = {quo_reg[W-2:0], alu_sum[W]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    state_next = ST_DIV_FIN;
                end
            end

            ST_DIV_FIN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = second_addr;
                ram_wdata  = alu_sum[W-1:0];
                depth_next = depth_reg - DW'(1);
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_load       = 1'b1;
                    rsp_next.kind  = kind_reg;
                    rsp_next.value = val_reg;
                    rsp_next.error = err_reg;
                    rsp_next.last  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_SHOW_DEPTH:
            begin
                if (rsp_free)
                begin
                    rsp_load       = 1'b1;
                    rsp_next.kind  = fdsa_pkg::KIND_DEPTH;
                    rsp_next.value = W'(depth_reg);
                    rsp_next.error = fdsa_pkg::ERR_NONE;
                    rsp_next.last  = (depth_reg == '0);
                    if (depth_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = top_addr;
                        idx_next   = top_addr;
                        state_next = ST_SHOW_ENT;
                    end
                end
            end

            ST_SHOW_ENT:
            begin
                // load this entry and fetch the one below in the same cycle
                if (rsp_free)
                begin
                    rsp_load       = 1'b1;
                    rsp_next.kind  = fdsa_pkg::KIND_ENTRY;
                    rsp_next.value = ram_rdata;
                    rsp_next.error = fdsa_pkg::ERR_NONE;
                    rsp_next.last  = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg - AW'(1);
                        idx_next   = idx_reg - AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_valid_next = rsp_free ? rsp_load : rsp_valid_reg;
    end

    fdsa_ram #(
        .WIDTH (W),
        .DEPTH (STACK_ENTRIES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
        err_reg  <= err_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(STACK_ENTRIES))
        else $error("stack depth beyond capacity");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> cmd_stall)
        else $error("new beat taken while an item is in progress");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dvs_reg != '0))
        else $error("divide loop running on a zero divisor");

    a_multi_beat_show: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && !rsp_next.last) |-> (state_next == ST_SHOW_ENT))
        else $error("non-final beat outside the stack walk");

endmodule

[src/fdsa_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// fdsa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module fdsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // hold read data until the next read
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[test/forth_data_stack_alu_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// forth_data_stack_alu_tb: self-checking bench for the Forth data stack ALU
// Feeds Forth words through the cmd channel and checks every rsp beat against
// a cycle-free predictor that keeps its own copy of the data stack. Covers
// underflow, overflow, divide by zero, the most negative quotient, full-stack
// dumps and unused opcodes, then a long random mix with random idle and stall.
// ============================================================================
module forth_data_stack_alu_tb;

    localparam int         STACK_ENTRIES  = fdsa_pkg::STACK_ENTRIES_DEF;
    localparam int         RANDOM_WORDS   = 180;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SETTLE_CYCLES  = 50;
    localparam int         REPORT_MAX     = 10;
    // opcodes the block leaves unused: they only answer with a status beat
    localparam logic [3:0] MODE_SPARE_LO  = 4'd12;
    localparam logic [3:0] MODE_SPARE_HI  = 4'd15;

    typedef struct {
        fdsa_pkg::cmd_beat_t beat;
        bit                  drain;   // hold this word back until every answer is in
    } word_item_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    fdsa_pkg::cmd_beat_t cmd       = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    fdsa_pkg::rsp_beat_t rsp;

    // words waiting to be driven, and rsp beats still owed by the block
    word_item_t          word_queue[$];
    fdsa_pkg::rsp_beat_t answer_queue[$];

    // predictor copy of the data stack
    logic [31:0] stk [STACK_ENTRIES];
    int          stk_depth = 0;

    // depth as the stimulus planner sees it (value independent)
    int plan_depth    = 0;
    int words_planned = 0;

    int words_sent   = 0;
    int beats_seen   = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    forth_data_stack_alu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Literals lean on the corner values so that wrap, zero divisors and the
    // most negative quotient come up often in the random mix.
    function automatic logic [31:0] pick_literal();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return 32'($urandom_range(0, 40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_word(logic [3:0] mode, logic [31:0] literal, bit drain);
        word_item_t item;
        item.beat.mode    = mode;
        item.beat.literal = literal;
        item.drain        = drain;
        word_queue.push_back(item);
        words_planned++;
        // track depth only; divide by zero also nets one entry less
        case (mode)
            fdsa_pkg::MODE_PUSH:
                if (plan_depth < STACK_ENTRIES)
                    plan_depth++;
            fdsa_pkg::MODE_ADD, fdsa_pkg::MODE_SUB, fdsa_pkg::MODE_MUL,
            fdsa_pkg::MODE_DIV:
                if (plan_depth >= 2)
                    plan_depth--;
            fdsa_pkg::MODE_DUP:
                if (plan_depth >= 1 && plan_depth < STACK_ENTRIES)
                    plan_depth++;
            fdsa_pkg::MODE_OVER:
                if (plan_depth >= 2 && plan_depth < STACK_ENTRIES)
                    plan_depth++;
            fdsa_pkg::MODE_DROP, fdsa_pkg::MODE_PRINT, fdsa_pkg::MODE_EMIT:
                if (plan_depth >= 1)
                    plan_depth--;
            default: ;
        endcase
    endfunction

    function automatic void owe_beat(logic [2:0] kind, logic [31:0] value, logic [1:0] err,
                                     bit last);
        fdsa_pkg::rsp_beat_t beat;
        beat.kind  = kind;
        beat.value = value;
        beat.error = err;
        beat.last  = last;
        answer_queue.push_back(beat);
    endfunction

    function automatic logic [31:0] stack_take();
        stk_depth--;
        return stk[stk_depth];
    endfunction

    function automatic void stack_put(logic [31:0] v);
        stk[stk_depth] = v;
        stk_depth++;
    endfunction

    // Apply one Forth word to the predictor stack and queue the beats it owes.
    function automatic void run_word(fdsa_pkg::cmd_beat_t w);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        case (w.mode)
            fdsa_pkg::MODE_PUSH:
                if (stk_depth >= STACK_ENTRIES)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_OVERFLOW, 1'b1);
                else
                begin
                    stack_put(w.literal);
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_NONE, 1'b1);
                end
            fdsa_pkg::MODE_ADD, fdsa_pkg::MODE_SUB, fdsa_pkg::MODE_MUL,
            fdsa_pkg::MODE_DIV:
                if (stk_depth < 2)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_UNDERFLOW, 1'b1);
                else
                begin
                    b = stack_take();
                    if (w.mode == fdsa_pkg::MODE_DIV && b == 32'd0)
                        // divisor is consumed, dividend stays
                        owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_DIV_ZERO, 1'b1);
                    else
                    begin
                        a = stack_take();
                        case (w.mode)
                            fdsa_pkg::MODE_ADD: r = a + b;
                            fdsa_pkg::MODE_SUB: r = a - b;
                            fdsa_pkg::MODE_MUL: r = a * b;
                            default:
                                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                                    r = a;
                                else
                                    r = $signed(a) / $signed(b);
                        endcase
                        stack_put(r);
                        owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_NONE, 1'b1);
                    end
                end
            fdsa_pkg::MODE_DUP:
                if (stk_depth < 1)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_UNDERFLOW, 1'b1);
                else if (stk_depth >= STACK_ENTRIES)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_OVERFLOW, 1'b1);
                else
                begin
                    stack_put(stk[stk_depth - 1]);
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_NONE, 1'b1);
                end
            fdsa_pkg::MODE_DROP:
                if (stk_depth < 1)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_UNDERFLOW, 1'b1);
                else
                begin
                    stk_depth--;
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_NONE, 1'b1);
                end
            fdsa_pkg::MODE_SWAP:
                if (stk_depth < 2)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_UNDERFLOW, 1'b1);
                else
                begin
                    a                  = stk[stk_depth - 2];
                    stk[stk_depth - 2] = stk[stk_depth - 1];
                    stk[stk_depth - 1] = a;
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_NONE, 1'b1);
                end
            fdsa_pkg::MODE_OVER:
                if (stk_depth < 2)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_UNDERFLOW, 1'b1);
                else if (stk_depth >= STACK_ENTRIES)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_OVERFLOW, 1'b1);
                else
                begin
                    stack_put(stk[stk_depth - 2]);
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_NONE, 1'b1);
                end
            fdsa_pkg::MODE_PRINT, fdsa_pkg::MODE_EMIT:
                if (stk_depth < 1)
                    owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_UNDERFLOW, 1'b1);
                else
                begin
                    a = stack_take();
                    if (w.mode == fdsa_pkg::MODE_PRINT)
                        owe_beat(fdsa_pkg::KIND_NUMBER, a, fdsa_pkg::ERR_NONE, 1'b1);
                    else
                        owe_beat(fdsa_pkg::KIND_CHAR, {24'd0, a[7:0]}, fdsa_pkg::ERR_NONE,
                                 1'b1);
                end
            fdsa_pkg::MODE_SHOW:
            begin
                // depth first, then entries from top to bottom
                owe_beat(fdsa_pkg::KIND_DEPTH, 32'(stk_depth), fdsa_pkg::ERR_NONE,
                         stk_depth == 0);
                for (int i = stk_depth; i > 0; i--)
                    owe_beat(fdsa_pkg::KIND_ENTRY, stk[i - 1], fdsa_pkg::ERR_NONE, i == 1);
            end
            default:
                owe_beat(fdsa_pkg::KIND_STATUS, '0, fdsa_pkg::ERR_NONE, 1'b1);
        endcase
    endfunction

    task automatic note_failure(string what, fdsa_pkg::rsp_beat_t want,
                                fdsa_pkg::rsp_beat_t got);
        if (mismatches < REPORT_MAX)
            $display("%0t %s: expected kind %0d value %h error %0d last %0d,",
                     $realtime, what, want.kind, want.value, want.error, want.last,
                     " got kind %0d value %h error %0d last %0d",
                     got.kind, got.value, got.error, got.last);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued words, hold while stalled, idle between beats.
    // A word flagged drain waits until the block owes nothing and no cmd beat
    // moved on this edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                words_sent++;
                // every third stretch of 32 words runs back to back
                gap_left = ((words_sent / 32) % 3 == 0) ? 0 : pick_gap();
            end
            if (cmd_valid && cmd_stall)
            begin
                // hold the stalled beat as it is
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                cmd_valid <= 1'b0;
            end
            else if (word_queue.size() != 0 &&
                     !(word_queue[0].drain && (cmd_valid || answer_queue.size() != 0)))
            begin
                cmd       <= word_queue[0].beat;
                cmd_valid <= 1'b1;
                word_queue.pop_front();
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check the rsp beat taken on this edge against the oldest owed
    // beat, then run the cmd beat taken on this edge through the predictor.
    // Checking first keeps a fresh prediction from matching a stray beat.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                beats_seen++;
                if (answer_queue.size() == 0)
                    note_failure("unexpected beat", '0, rsp);
                else
                begin
                    if (rsp.kind !== answer_queue[0].kind ||
                        rsp.value !== answer_queue[0].value ||
                        rsp.error !== answer_queue[0].error ||
                        rsp.last !== answer_queue[0].last)
                        note_failure("rsp mismatch", answer_queue[0], rsp);
                    answer_queue.pop_front();
                end
            end
            if (cmd_valid && !cmd_stall)
                run_word(cmd);

            // stall the rsp side at random; one stretch in three never stalls
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if ((beats_seen / 48) % 3 != 1 && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when neither channel moves for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int          directed;
        int          n;
        int          k;
        logic [3:0]  m;

        // Directed: add, drop, print, emit, dup, swap and show on an empty stack, the
        // unused opcodes, wrap, most negative divided by minus one, zero divisor, truncation.
        queue_word(fdsa_pkg::MODE_ADD, pick_literal(), 1'b0);
        queue_word(fdsa_pkg::MODE_DROP, pick_literal(), 1'b0);
        queue_word(fdsa_pkg::MODE_PRINT, pick_literal(), 1'b0);
        queue_word(fdsa_pkg::MODE_EMIT, pick_literal(), 1'b0);
        queue_word(fdsa_pkg::MODE_DUP, pick_literal(), 1'b0);
        queue_word(fdsa_pkg::MODE_SWAP, pick_literal(), 1'b0);
        queue_word(fdsa_pkg::MODE_SHOW, pick_literal(), 1'b0);
        queue_word(MODE_SPARE_LO, 32'hFFFF_FFFF, 1'b0);
        queue_word(MODE_SPARE_HI, 32'h0000_0000, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_word(fdsa_pkg::MODE_OVER, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'h0000_0001, 1'b0);
        queue_word(fdsa_pkg::MODE_ADD, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1'b0);
        queue_word(fdsa_pkg::MODE_DIV, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'h0000_0000, 1'b0);
        queue_word(fdsa_pkg::MODE_DIV, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'hFFFF_FFF9, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'h0000_0002, 1'b0);
        queue_word(fdsa_pkg::MODE_DIV, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_MUL, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'h0000_0005, 1'b0);
        queue_word(fdsa_pkg::MODE_SUB, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_OVER, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_SWAP, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_DUP, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_SHOW, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_PRINT, 32'h0, 1'b0);
        queue_word(fdsa_pkg::MODE_PUSH, 32'hFFFF_FF80, 1'b0);
        queue_word(fdsa_pkg::MODE_EMIT, 32'h0, 1'b0);
        directed = words_planned;

        // Let the block drain fully once before the random part.
        queue_word(fdsa_pkg::MODE_SHOW, pick_literal(), 1'b1);

        while (words_planned < directed + RANDOM_WORDS)
        begin
            k = $urandom_range(0, 19);
            if (k < 2)
            begin
                // fill to the brim, hit every overflow, dump, then unwind
                while (plan_depth < STACK_ENTRIES)
                    queue_word(fdsa_pkg::MODE_PUSH, pick_literal(), 1'b0);
                queue_word(fdsa_pkg::MODE_PUSH, pick_literal(), 1'b0);
                queue_word(fdsa_pkg::MODE_DUP, pick_literal(), 1'b0);
                queue_word(fdsa_pkg::MODE_OVER, pick_literal(), 1'b0);
                queue_word(fdsa_pkg::MODE_SHOW, pick_literal(), 1'b0);
                n = $urandom_range(3, 30);
                repeat (n)
                    queue_word($urandom_range(0, 1) ? fdsa_pkg::MODE_DROP
                                                    : fdsa_pkg::MODE_PRINT,
                               pick_literal(), 1'b0);
            end
            else if (k < 4)
            begin
                // noise: any opcode, unused ones included
                n = $urandom_range(4, 10);
                repeat (n)
                    queue_word(4'($urandom_range(0, 15)), pick_literal(), 1'b0);
            end
            else if (k < 5)
                queue_word(fdsa_pkg::MODE_SHOW, pick_literal(), 1'($urandom_range(0, 1)));
            else
            begin
                // well-formed work: keep operands around, then mix every word
                n = $urandom_range(6, 16);
                repeat (n)
                begin
                    if (plan_depth < 2 && $urandom_range(0, 3) != 0)
                        m = fdsa_pkg::MODE_PUSH;
                    else
                    begin
                        k = $urandom_range(0, 15);
                        m = (k > fdsa_pkg::MODE_SHOW) ? fdsa_pkg::MODE_PUSH : 4'(k);
                    end
                    queue_word(m, pick_literal(), 1'b0);
                end
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // sample away from the active edge so queue updates have settled
        while (word_queue.size() != 0 || cmd_valid || answer_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        while (answer_queue.size() != 0)
        begin
            note_failure("beat never arrived", answer_queue[0], '0);
            answer_queue.pop_front();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
